// ===== src/mm3_pkg.sv =====
// Shared types and constants for the MurmurHash3 x86_32 byte hasher.
package mm3_pkg;

    // Mixing and finalizer constants of the x86_32 variant.
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_ADD   = 32'he6546b64;
    localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;
    localparam logic [31:0] SEED_INIT = 32'd42;

    // Depth of the job queue between the byte packer and the mixer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One unit of work for the mixer: a full block, or the message tail.
    typedef struct packed {
        logic [31:0] word;      // little-endian block or zero-padded tail
        logic        full;      // four bytes: full block mix
        logic        last;      // message ends with this job
        logic        first;     // first job of the message
        logic [31:0] length;    // byte length of the message, valid on last
        logic [31:0] seed;      // seed of the message, used on first
    } t_job;

    // Rotate helpers for the block mix.
    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

endpackage

// ===== src/mm3_front.sv =====
// Byte packer: gathers message bytes into blocks and issues mixer jobs.
module mm3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_job_full,
    output logic          o_job_push,
    output mm3_pkg::t_job o_job
);
    import mm3_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_msg_seed;
    logic [23:0] r_partial;
    logic [1:0]  r_cnt;
    logic [31:0] r_len;
    logic        r_busy;
    logic        r_sent;

    logic        accept;
    logic        emit;
    logic [31:0] len_n;
    logic [31:0] seed_cur;
    logic [31:0] merged;

    assign accept   = i_push && !i_job_full;
    assign len_n    = r_len + 32'd1;
    assign seed_cur = r_busy ? r_msg_seed : r_seed;
    assign emit     = (r_cnt == 2'd3) || i_last_byte;

    // Place the new byte at its little-endian lane above the bytes so far.
    always_comb begin
        unique case (r_cnt)
            2'd0: merged = {24'd0, i_data_byte};
            2'd1: merged = {16'd0, i_data_byte, r_partial[7:0]};
            2'd2: merged = {8'd0, i_data_byte, r_partial[15:0]};
            2'd3: merged = {i_data_byte, r_partial};
            default: merged = {i_data_byte, r_partial};
        endcase
    end

    // Job handed to the queue on a full block or on the final byte.
    assign o_job_push   = accept && emit;
    assign o_job.word   = merged;
    assign o_job.full   = (r_cnt == 2'd3);
    assign o_job.last   = i_last_byte;
    assign o_job.first  = !r_sent;
    assign o_job.length = len_n;
    assign o_job.seed   = seed_cur;

    // Seed register, written through the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_INIT;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    // Per-message packing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_busy    <= 1'b0;
            r_sent    <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_partial <= '0;
                r_cnt     <= '0;
                r_len     <= '0;
                r_busy    <= 1'b0;
                r_sent    <= 1'b0;
            end else begin
                r_partial <= (r_cnt == 2'd3) ? 24'd0 : merged[23:0];
                r_cnt     <= r_cnt + 2'd1;
                r_len     <= len_n;
                r_busy    <= 1'b1;
                r_sent    <= r_sent || emit;
            end
        end
    end

    // The message seed is captured as the first byte arrives.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_msg_seed <= seed_cur;
        end
    end

    // A final byte always closes the message and restarts the packer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> (r_cnt == 2'd0) && !r_busy && !r_sent)
        else $error("packer did not restart after the final byte");

    // Every fourth byte of a message produces a job.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_cnt == 2'd3) |-> o_job_push && o_job.full)
        else $error("full block was not issued");

endmodule

// ===== src/mm3_queue.sv =====
// Short job queue between the byte packer and the mixer.
module mm3_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mm3_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output mm3_pkg::t_job o_job,
    output logic          o_empty
);
    import mm3_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue overfilled");

endmodule

// ===== src/mm3_back.sv =====
// Mixer: runs block mixes and the finalizer as a sequence of multiply steps.
module mm3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mm3_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [31:0]   o_hash_value
);
    import mm3_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_FIN0 = 3'd4;
    localparam logic [2:0] S_FIN1 = 3'd5;
    localparam logic [2:0] S_FIN2 = 3'd6;
    localparam logic [2:0] S_FIN3 = 3'd7;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    t_job        r_job;
    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_hash;

    logic        load_job;
    logic        load_out;
    logic [31:0] mixed;
    logic [31:0] fin_t;
    logic [31:0] fin_x;

    assign mixed = rotl13(r_h ^ r_acc);
    assign fin_t = r_h ^ r_job.length;
    assign fin_x = r_acc ^ {13'd0, r_acc[31:13]};

    assign load_job = (r_state == S_IDLE) && !i_job_empty;
    assign load_out = (r_state == S_FIN3) && (!r_out_valid || i_pop);
    assign o_job_pop = load_job;

    // Sequencer: one multiply per step, registered before the next.
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_acc   = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (load_job) begin
                    if (i_job.first) begin
                        n_h = i_job.seed;
                    end
                    n_state = S_K1;
                end
            end
            S_K1: begin
                n_acc   = r_job.word * MIX_C1;
                n_state = S_K2;
            end
            S_K2: begin
                n_acc   = rotl15(r_acc) * MIX_C2;
                n_state = S_MIX;
            end
            S_MIX: begin
                if (r_job.full) begin
                    n_h = (mixed << 2) + mixed + MIX_ADD;
                end else begin
                    n_h = r_h ^ r_acc;
                end
                n_state = r_job.last ? S_FIN0 : S_IDLE;
            end
            S_FIN0: begin
                n_acc   = fin_t ^ {16'd0, fin_t[31:16]};
                n_state = S_FIN1;
            end
            S_FIN1: begin
                n_acc   = r_acc * FIN_C1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_acc   = fin_x * FIN_C2;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result register: loaded by the finalizer, cleared by a transfer out.
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_acc <= n_acc;
        if (load_job) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_out_hash <= r_acc ^ {16'd0, r_acc[31:16]};
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_out_hash;

    // A waiting result is never overwritten before its transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out_hash))
        else $error("pending hash was overwritten");

    // Jobs are taken only by an idle sequencer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == S_IDLE) && !i_job_empty)
        else $error("job taken while mixer busy");

endmodule

// ===== src/murmur3_32_byte_hasher_top.sv =====
// Top level of the MurmurHash3 x86_32 byte-stream hasher.
//
// Usage: a message enters one byte per transfer on the push/full side, with
// i_last_byte set on its final byte. One 32-bit hash leaves per message on
// the empty/pop side, in message order. The seed is written through the
// i_cfg_valid/o_cfg_ready channel (always ready) and applies from the next
// message that starts after the write; reset loads seed 42.
// Bytes are packed into little-endian blocks by the front end, which takes
// one byte per cycle while the queue is not full. Every fourth byte and
// every final byte becomes a job in a two-entry queue. The mixer runs a block
// job through the steps IDLE, K1, K2 and MIX, and a final job (tail or block
// mix plus finalizer) on through FIN0 to FIN3, at most one 32-bit multiply
// per step, so block mixing keeps pace with one byte per cycle; short
// messages back to back are limited by the finalizer, the queue filling and
// stalling the input. A message's hash is loaded into the output register
// in FIN3 of its final job, which starts only after all earlier jobs.
// full rises while the queue holds two jobs; when the receiver does not pop,
// the result stays in the output register, the mixer waits in its last
// step, and the queue then fills and stalls the input.
// Synchronous reset clears packer, queue, mixer and output control state.
module murmur3_32_byte_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_hash_value
);
    import mm3_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;

    assign o_cfg_ready = 1'b1;
    assign o_full      = job_full;

    // Byte packer.
    mm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_job_full  (job_full),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    // Job queue.
    mm3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_empty (job_empty)
    );

    // Mixer and result register.
    mm3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (queue_job),
        .i_job_empty  (job_empty),
        .o_job_pop    (job_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_hash_value (o_hash_value)
    );

endmodule

// ===== tb/hash_tracker_pkg.sv =====
// Scoreboard class that predicts and checks MurmurHash3 x86_32 message hashes.
package hash_tracker_pkg;
    import mm3_pkg::*;

    class hash_tracker;
        // Seed register and the per-message hashing state.
        logic [31:0] seed;
        logic [31:0] running_hash;
        logic [23:0] tail_bytes;
        logic [1:0]  tail_count;
        logic [31:0] msg_length;
        bit          in_message;

        // Hashes of finished messages that have not left the block yet.
        logic [31:0] pending_hashes[$];

        int unsigned bytes_taken;
        int unsigned messages_done;
        int unsigned hashes_checked;
        int unsigned mismatches;

        function new();
            seed           = SEED_INIT;
            bytes_taken    = 0;
            messages_done  = 0;
            hashes_checked = 0;
            mismatches     = 0;
            restart_message();
        endfunction

        // Every message starts over from the current seed.
        function void restart_message();
            running_hash = seed;
            tail_bytes   = '0;
            tail_count   = '0;
            msg_length   = '0;
            in_message   = 1'b0;
        endfunction

        function logic [31:0] rotate_left(logic [31:0] x, int unsigned r);
            return (x << r) | (x >> (32 - r));
        endfunction

        // Scrambling of one 32-bit block before it enters the hash.
        function logic [31:0] block_mix(logic [31:0] k);
            k = k * MIX_C1;
            k = rotate_left(k, 15);
            k = k * MIX_C2;
            return k;
        endfunction

        // Final avalanche applied once the length has been folded in.
        function logic [31:0] avalanche(logic [31:0] h);
            h = h ^ (h >> 16);
            h = h * FIN_C1;
            h = h ^ (h >> 13);
            h = h * FIN_C2;
            h = h ^ (h >> 16);
            return h;
        endfunction

        // A new seed reaches the hash at once only between messages.
        function void load_seed(logic [31:0] value);
            seed = value;
            if (!in_message)
                running_hash = value;
        endfunction

        // Account for one accepted byte and queue the hash on the final one.
        function void take_byte(logic [7:0] data, logic last);
            logic [31:0] h;
            h = running_hash;
            msg_length = msg_length + 32'd1;
            bytes_taken++;
            if (tail_count == 2'd3) begin
                h = h ^ block_mix({data, tail_bytes});
                h = rotate_left(h, 13);
                h = h * 32'd5 + MIX_ADD;
                tail_bytes = '0;
                tail_count = '0;
            end else begin
                tail_bytes[8 * tail_count +: 8] = data;
                tail_count = tail_count + 2'd1;
            end
            if (!last) begin
                running_hash = h;
                in_message   = 1'b1;
                return;
            end
            if (tail_count != 2'd0)
                h = h ^ block_mix({8'h00, tail_bytes});
            h = h ^ msg_length;
            pending_hashes.push_back(avalanche(h));
            messages_done++;
            restart_message();
        endfunction

        // Compare one hash that left the block with the oldest pending one.
        function void compare_hash(logic [31:0] actual);
            logic [31:0] want;
            if (pending_hashes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected hash %08h with no message pending.", actual);
                return;
            end
            want = pending_hashes.pop_front();
            hashes_checked++;
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Hash mismatch on message %0d: expected %08h, got %08h.",
                             hashes_checked, want, actual);
            end
        endfunction
    endclass

endpackage

// ===== tb/murmur3_32_byte_hasher_top_tb.sv =====
// Testbench for the MurmurHash3 x86_32 byte hasher: directed and random messages.
module murmur3_32_byte_hasher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hash_tracker_pkg::*;

    localparam int   PHASES        = 6;
    localparam int   PHASE_BYTES   = 272;
    localparam int   STEADY_PHASE  = 3;
    localparam int   SETTLE_CYCLES = 24;
    localparam int   STALL_LIMIT   = 2000;
    localparam logic MORE          = 1'b0;
    localparam logic END_MSG       = 1'b1;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_push      = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_pop       = 1'b0;
    logic        o_cfg_ready;
    logic        o_full;
    logic        o_empty;
    logic [31:0] o_hash_value;

    bit          steady      = 1'b0;
    int          stall_cycles = 0;
    int unsigned seed_writes = 0;
    hash_tracker hashes;

    murmur3_32_byte_hasher_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_hash_value (o_hash_value)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: check each transfer, then decide whether to stall next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty)
                hashes.compare_hash(o_hash_value);
            i_pop <= steady || ($urandom_range(99) >= 10);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Offer one byte, with an occasional idle gap first, until it is taken.
    task automatic push_byte(input logic [7:0] data, input logic last);
        if (!steady && $urandom_range(99) < 10) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        hashes.take_byte(data, last);
    endtask

    task automatic halt_push();
        i_push <= 1'b0;
    endtask

    // Hold off until every pending hash has arrived and the mixer has settled.
    task automatic wait_for_hashes();
        while (hashes.pending_hashes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Seed write on the configuration channel.
    task automatic write_seed(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        hashes.load_seed(value);
        seed_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Random bytes; the final one carries the end flag only when asked.
    task automatic send_random_message(input int unsigned len, input bit close);
        for (int unsigned n = 1; n <= len; n++)
            push_byte(8'($urandom), close && (n == len));
    endtask

    // Mostly short messages, now and then a long one.
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 32);
        else if (r < 99)
            return $urandom_range(33, 100);
        return $urandom_range(200, 300);
    endfunction

    initial begin
        int unsigned phase_end;
        hashes = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset seed: single bytes at both extremes, two- and three-byte tails.
        push_byte(8'h00, END_MSG);
        push_byte(8'hff, END_MSG);
        push_byte(8'h01, MORE);
        push_byte(8'h80, END_MSG);
        push_byte(8'hff, MORE);
        push_byte(8'hff, MORE);
        push_byte(8'hff, END_MSG);
        halt_push();
        wait_for_hashes();

        // All-ones seed: one full block, then a full block plus a one-byte tail.
        write_seed(32'hffff_ffff);
        push_byte(8'h12, MORE);
        push_byte(8'h34, MORE);
        push_byte(8'h56, MORE);
        push_byte(8'h78, END_MSG);
        push_byte(8'haa, MORE);
        push_byte(8'h55, MORE);
        push_byte(8'ha5, MORE);
        push_byte(8'h5a, MORE);
        push_byte(8'hc3, END_MSG);
        halt_push();
        wait_for_hashes();

        // Zero seed, then a seed change in the middle of a message: the open
        // message keeps its hash and only the next one sees the new seed.
        write_seed(32'h0000_0000);
        push_byte(8'hde, MORE);
        push_byte(8'had, MORE);
        halt_push();
        wait_for_hashes();
        write_seed(32'h5a5a_a5a5);
        push_byte(8'hbe, MORE);
        push_byte(8'hef, MORE);
        push_byte(8'h01, END_MSG);
        push_byte(8'h77, END_MSG);
        halt_push();
        wait_for_hashes();

        // Random phases, each under its own seed; some end inside a message.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_seed(32'h0000_0000);
                end
                1: begin
                    write_seed(32'hffff_ffff);
                end
                default: begin
                    write_seed($urandom);
                end
            endcase
            steady <= (phase == STEADY_PHASE);
            phase_end = hashes.bytes_taken + PHASE_BYTES;
            while (hashes.bytes_taken < phase_end)
                send_random_message(pick_length(), 1'b1);
            if (phase != PHASES - 1 && $urandom_range(2) == 0)
                send_random_message($urandom_range(1, 6), 1'b0);
            halt_push();
            wait_for_hashes();
        end

        // Report coverage of the run, then the verdict.
        $display("Hashed %0d bytes in %0d messages under %0d seed writes.",
                 hashes.bytes_taken, hashes.messages_done, seed_writes);
        $display("Checked %0d hashes, %0d mismatches, %0d still pending.",
                 hashes.hashes_checked, hashes.mismatches,
                 hashes.pending_hashes.size());
        if (hashes.mismatches == 0 && hashes.pending_hashes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mm3_pkg.sv
src/mm3_front.sv
src/mm3_queue.sv
src/mm3_back.sv
src/murmur3_32_byte_hasher_top.sv
tb/hash_tracker_pkg.sv
tb/murmur3_32_byte_hasher_top_tb.sv
